// ===== sv/bpc_pkg.sv =====
// Shared types, reset values and register indexes for the button press classifier.
`default_nettype none

package bpc_pkg;

  // Default width of the internal timestamp arithmetic.
  localparam int TIME_WIDTH_DEFAULT = 32;

  // Configuration register file.
  localparam int CFG_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 1;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SHORT_MS = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_MS  = 1'd1;

  localparam logic [CFG_WIDTH-1:0] SHORT_MS_RESET = 16'd50;
  localparam logic [CFG_WIDTH-1:0] LONG_MS_RESET  = 16'd1000;

  // Width of the timestamp and held-time fields on the ports.
  localparam int STAMP_WIDTH = 32;

  typedef struct packed {
    logic                   level;
    logic [STAMP_WIDTH-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic                   pressed_new;
    logic                   released_new;
    logic                   released_short_new;
    logic                   released_long_new;
    logic                   long_press_new;
    logic                   short_held;
    logic [STAMP_WIDTH-1:0] held_ms;
  } result_t;

  // Single-bit tracking state kept between requests.
  typedef struct packed {
    logic last_level;
    logic long_reported;
  } flags_t;

endpackage

`default_nettype wire

// ===== sv/bpc_stream_if.sv =====
// Valid/ready stream interface carrying one payload per request.
`default_nettype none

interface bpc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/button_press_classifier.sv =====
// Top level of the button press classifier: request register, evaluation and result register.
`default_nettype none

// The button press classifier takes one request per control cycle, holding
// the button level and a free-running millisecond timestamp, and returns one
// result per request: edge pulses for press and release, a release pulse
// split into short and long holds, a once-per-hold pulse when the hold
// reaches long_ms, a short-hold flag and the held time (at least 1 while
// down, 0 while up). Time differences wrap modulo 2^TIME_WIDTH. A request
// is captured into an input register, classified by a single pass of
// compare and subtract logic, and written into a result register, so one
// request is accepted every clock cycle unless the result side stalls.
// The result is loaded from the input register into the result register
// when the pipeline advances, and is taken from there. The only stall comes
// from the result side: while the result register holds an untaken
// result, the whole two-stage pipeline holds and the request side sees
// ready low. Registers short_ms (index 0) and long_ms (index 1) should be
// written only while the block is idle.

module button_press_classifier #(
  parameter int TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bpc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  bpc_stream_if.sink                        item,
  bpc_stream_if.source                      result
);
  import bpc_pkg::*;

  // Configuration registers.
  logic [CFG_WIDTH-1:0] short_ms;
  logic [CFG_WIDTH-1:0] long_ms;

  // Input register stage.
  logic                  s1_valid;
  logic                  s1_level;
  logic [TIME_WIDTH-1:0] s1_now;

  // Press tracking state. The release timestamp is never needed after the
  // cycle of the release itself, so only the press timestamp is kept.
  flags_t                flags;
  flags_t                flags_next;
  logic [TIME_WIDTH-1:0] press_stamp;
  logic [TIME_WIDTH-1:0] press_stamp_next;

  // Result register stage.
  logic    res_valid;
  result_t res_data;
  result_t res_next;

  logic                  advance;
  logic [TIME_WIDTH-1:0] now_t;

  // The pipeline moves as a whole whenever the result register is free or
  // being emptied in this cycle.
  assign advance     = !res_valid || result.ready;
  assign item.ready  = advance;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  // Only the low TIME_WIDTH bits of the timestamp take part in the timing.
  if (TIME_WIDTH <= STAMP_WIDTH) begin : g_now_trunc
    assign now_t = item.data.now_ms[TIME_WIDTH-1:0];
  end else begin : g_now_ext
    assign now_t = {{(TIME_WIDTH-STAMP_WIDTH){1'b0}}, item.data.now_ms};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ms <= SHORT_MS_RESET;
      long_ms  <= LONG_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_MS: short_ms <= cfg_wdata;
        CFG_LONG_MS:  long_ms  <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Capture a request into the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.valid) begin
      s1_level <= item.data.level;
      s1_now   <= now_t;
    end
  end

  bpc_eval #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_eval (
    .flags            (flags),
    .press_stamp      (press_stamp),
    .level            (s1_level),
    .now_t            (s1_now),
    .short_ms         (short_ms),
    .long_ms          (long_ms),
    .flags_next       (flags_next),
    .press_stamp_next (press_stamp_next),
    .res              (res_next)
  );

  // The tracking state commits together with the result it produced.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags       <= '0;
      press_stamp <= '0;
      res_valid   <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        flags       <= flags_next;
        press_stamp <= press_stamp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_data <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bpc_eval.sv =====
// Combinational classification of one request against the held press state.
`default_nettype none

module bpc_eval #(
  parameter int TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEFAULT
) (
  input  bpc_pkg::flags_t                flags,
  input  logic [TIME_WIDTH-1:0]          press_stamp,
  input  logic                           level,
  input  logic [TIME_WIDTH-1:0]          now_t,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]  short_ms,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]  long_ms,
  output bpc_pkg::flags_t                flags_next,
  output logic [TIME_WIDTH-1:0]          press_stamp_next,
  output bpc_pkg::result_t               res
);
  import bpc_pkg::*;

  logic                  changed;
  logic [TIME_WIDTH-1:0] dt;
  logic [TIME_WIDTH-1:0] held;
  logic                  long_hit;
  logic                  short_hit;
  logic                  reported_base;
  logic                  long_new;

  always_comb begin
    changed          = level != flags.last_level;
    press_stamp_next = (changed && level) ? now_t : press_stamp;
    // On a release the span since the press is the same difference.
    dt               = now_t - press_stamp_next;
    long_hit         = dt >= TIME_WIDTH'(long_ms);
    short_hit        = dt >= TIME_WIDTH'(short_ms);
    reported_base    = (changed && !level) ? 1'b0 : flags.long_reported;
    long_new         = level && !reported_base && long_hit;
    held             = level ? ((dt == '0) ? TIME_WIDTH'(1) : dt) : '0;

    flags_next.last_level    = level;
    flags_next.long_reported = reported_base | long_new;

    res.pressed_new        = changed && level;
    res.released_new       = changed && !level;
    res.released_short_new = changed && !level && !long_hit;
    res.released_long_new  = changed && !level && long_hit;
    res.long_press_new     = long_new;
    res.short_held         = level && short_hit && !long_hit;
  end

  if (TIME_WIDTH >= STAMP_WIDTH) begin : g_held_trunc
    assign res.held_ms = held[STAMP_WIDTH-1:0];
  end else begin : g_held_ext
    assign res.held_ms = {{(STAMP_WIDTH-TIME_WIDTH){1'b0}}, held};
  end

endmodule

`default_nettype wire

// ===== verif/button_press_classifier_tb.sv =====
// Self-checking testbench for the button press classifier with a request-level predictor.
`default_nettype none

// The testbench drives button requests into the classifier over the request
// channel and takes the results from the result channel. Every accepted
// request is run through a predictor that keeps its own copy of the button
// state and of the two thresholds. The expected result is queued, and every
// accepted result is compared field by field with the oldest one.
//
// The run has eight phases. Each phase uses one threshold setting and one
// pattern of gaps on the two sides. The thresholds are rewritten only once
// the block has drained. Most of the random stimulus is made of complete
// press and release episodes with hold times aimed at the thresholds. The
// rest is noise: random levels at random timestamps.

module button_press_classifier_tb;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 8;
  localparam int RANDOM_ITEMS = 180;
  localparam int DRAIN_CYCLES = 6;

  logic clk = 1'b0;
  logic rst;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]     cfg_wdata;

  bpc_stream_if #(.payload_t(item_t))   req_ch ();
  bpc_stream_if #(.payload_t(result_t)) res_ch ();

  button_press_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (req_ch),
    .result    (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Requests waiting for the driver, and results the predictor has computed
  // for requests that the block has already taken.
  item_t   queued_requests[$];
  result_t due_results[$];

  // Percent chance per cycle that the request side sits idle or that the
  // result side holds ready low. Both are set per phase.
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Predictor copy of the thresholds, updated together with each register write.
  logic [CFG_WIDTH-1:0] short_thr = SHORT_MS_RESET;
  logic [CFG_WIDTH-1:0] long_thr  = LONG_MS_RESET;

  // Predictor copy of the button state.
  logic                   btn_down    = 1'b0;
  logic [STAMP_WIDTH-1:0] press_at    = '0;
  logic [STAMP_WIDTH-1:0] release_at  = '0;
  logic                   long_done   = 1'b0;

  // Time base that the stimulus generator walks forward. It wraps with the
  // 32-bit timestamp.
  logic [STAMP_WIDTH-1:0] gen_clock = '0;

  result_t want;

  // Classifies one request and advances the predictor's button state. Edge
  // handling comes first, so the long-press check already sees a fresh press.
  function automatic result_t classify_press(item_t req);
    result_t                r;
    logic                   changed;
    logic [STAMP_WIDTH-1:0] dt;
    logic [STAMP_WIDTH-1:0] span;
    r = '0;
    changed = (req.level != btn_down);
    if (changed) begin
      btn_down = req.level;
      if (req.level) begin
        press_at   = req.now_ms;
        release_at = '0;
      end else begin
        release_at = req.now_ms;
        long_done  = 1'b0;
      end
    end
    if (req.level) begin
      // Held time wraps with the timestamp, and it never reads zero while down.
      dt = req.now_ms - press_at;
      if (!long_done && dt >= long_thr) begin
        long_done = 1'b1;
        r.long_press_new = 1'b1;
      end
      r.short_held = (dt >= short_thr) && (dt < long_thr);
      r.held_ms    = (dt == '0) ? 1 : dt;
    end else if (changed) begin
      span = release_at - press_at;
      if (span >= long_thr) r.released_long_new = 1'b1;
      else                  r.released_short_new = 1'b1;
    end
    r.pressed_new  = changed && req.level;
    r.released_new = changed && !req.level;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned exp_v,
                               input longint unsigned got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at cycle %0d: %s expected %0h, got %0h",
               cycle_count, what, exp_v, got_v);
  endtask

  task automatic add_request(input logic level, input logic [STAMP_WIDTH-1:0] now);
    item_t req;
    req.level  = level;
    req.now_ms = now;
    queued_requests.push_back(req);
  endtask

  // One well-formed hold: a few released requests, a press, some hold
  // requests at rising timestamps and a release at the end. The hold time is
  // aimed below, at and above both thresholds, with an occasional hold long
  // enough to wrap the timestamp.
  task automatic add_hold_episode(output int unsigned added);
    longint unsigned dur;
    longint unsigned off;
    int unsigned     holds;
    int unsigned     lead;
    added = 0;
    lead = $urandom_range(0, 2);
    repeat (lead) begin
      gen_clock += $urandom_range(0, 40);
      add_request(1'b0, gen_clock);
      added++;
    end
    case ($urandom_range(0, 7))
      0: dur = 64'($urandom_range(0, 3));
      1: dur = 64'($urandom_range(0, short_thr + 2));
      2: dur = 64'($urandom_range(short_thr, long_thr + 2));
      3: dur = (long_thr == 0) ? 64'd0 : 64'(long_thr - 16'd1);
      4: dur = 64'(long_thr);
      5: dur = 64'(long_thr) + 64'd1;
      6: dur = 64'($urandom_range(long_thr, 3 * long_thr + 10));
      default: dur = 64'($urandom);
    endcase
    gen_clock += $urandom_range(1, 60);
    add_request(1'b1, gen_clock);
    added++;
    holds = $urandom_range(0, 5);
    off = '0;
    repeat (holds) begin
      off = off + 64'($urandom_range(0, 32'(dur - off)));
      add_request(1'b1, gen_clock + off[STAMP_WIDTH-1:0]);
      added++;
    end
    gen_clock += dur[STAMP_WIDTH-1:0];
    add_request(1'b0, gen_clock);
    added++;
  endtask

  // Noise: random levels at fully random timestamps, including repeated
  // levels and timestamps that jump backward.
  task automatic add_noise(output int unsigned added);
    added = $urandom_range(1, 4);
    repeat (added) add_request(1'($urandom_range(0, 1)), $urandom);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SHORT_MS: short_thr = val;
      CFG_LONG_MS:  long_thr  = val;
      default: ;
    endcase
  endtask

  // Waits until every request has been taken and every result checked. By then
  // both pipeline stages are empty, and the clock runs on before returning.
  task automatic wait_drained();
    while (queued_requests.size() != 0 || req_ch.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver. It records the prediction when a request is accepted.
  // A new request is offered only once the current one is gone, so valid
  // never drops while a request waits.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        due_results.push_back(classify_press(req_ch.data));
      if (!req_ch.valid || req_ch.ready) begin
        if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.data  <= queued_requests.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      if (res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          note_mismatch("result with no request outstanding, held_ms", 0, res_ch.data.held_ms);
        end else begin
          want = due_results.pop_front();
          if (res_ch.data.pressed_new !== want.pressed_new)
            note_mismatch("pressed_new", want.pressed_new, res_ch.data.pressed_new);
          if (res_ch.data.released_new !== want.released_new)
            note_mismatch("released_new", want.released_new, res_ch.data.released_new);
          if (res_ch.data.released_short_new !== want.released_short_new)
            note_mismatch("released_short_new", want.released_short_new,
                          res_ch.data.released_short_new);
          if (res_ch.data.released_long_new !== want.released_long_new)
            note_mismatch("released_long_new", want.released_long_new,
                          res_ch.data.released_long_new);
          if (res_ch.data.long_press_new !== want.long_press_new)
            note_mismatch("long_press_new", want.long_press_new, res_ch.data.long_press_new);
          if (res_ch.data.short_held !== want.short_held)
            note_mismatch("short_held", want.short_held, res_ch.data.short_held);
          if (res_ch.data.held_ms !== want.held_ms)
            note_mismatch("held_ms", want.held_ms, res_ch.data.held_ms);
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned produced;
    int unsigned chunk;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_SHORT_MS;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    res_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      // Gap pattern: none, idle sender, stalling receiver, then both.
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 84; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 84; end
        default: begin send_gap_pct = 32; stall_pct = 32; end
      endcase

      // Threshold setting: reset values first, then zero, maximum, out of order,
      // widest window, random, the smallest nonzero pair and random again.
      case (phase)
        0: ;
        1: begin write_reg(CFG_SHORT_MS, 16'd0);     write_reg(CFG_LONG_MS, 16'd0);     end
        2: begin write_reg(CFG_SHORT_MS, 16'hFFFF);  write_reg(CFG_LONG_MS, 16'hFFFF);  end
        3: begin write_reg(CFG_SHORT_MS, 16'd500);   write_reg(CFG_LONG_MS, 16'd100);   end
        4: begin write_reg(CFG_SHORT_MS, 16'd0);     write_reg(CFG_LONG_MS, 16'hFFFF);  end
        6: begin write_reg(CFG_SHORT_MS, 16'd1);     write_reg(CFG_LONG_MS, 16'd2);     end
        default: begin
          write_reg(CFG_SHORT_MS, 16'($urandom_range(0, 300)));
          write_reg(CFG_LONG_MS, 16'($urandom_range(0, 3000)));
        end
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;

      if (phase == 0) begin
        // Idle start, then a hold that crosses the short and long thresholds
        // and is released long, with the long pulse firing only once.
        add_request(1'b0, 32'd0);
        add_request(1'b1, 32'd100);
        add_request(1'b1, 32'd120);
        add_request(1'b1, 32'd150);
        add_request(1'b1, 32'd1099);
        add_request(1'b1, 32'd1100);
        add_request(1'b1, 32'd1200);
        add_request(1'b0, 32'd1300);
        add_request(1'b0, 32'd1400);
        // A tap shorter than short_ms is still released as short.
        add_request(1'b1, 32'd2000);
        add_request(1'b0, 32'd2030);
        // A hold across the timestamp wrap.
        add_request(1'b1, 32'hFFFF_FFF0);
        add_request(1'b1, 32'h0000_0400);
        add_request(1'b0, 32'h0000_0410);
        // A timestamp one step backward gives the largest held time.
        add_request(1'b1, 32'h0000_0001);
        add_request(1'b1, 32'h0000_0000);
        add_request(1'b1, 32'hFFFF_FFFF);
        add_request(1'b0, 32'hFFFF_FFFF);
        // A press and release in the same millisecond.
        add_request(1'b1, 32'hAAAA_5555);
        add_request(1'b0, 32'hAAAA_5555);
        add_request(1'b1, 32'h5555_AAAA);
        add_request(1'b0, 32'h5555_AAAA + 32'd999);
        gen_clock = 32'h5555_B000;
      end

      produced = 0;
      while (produced < RANDOM_ITEMS) begin
        if ($urandom_range(0, 99) < 85) add_hold_episode(chunk);
        else                            add_noise(chunk);
        produced += chunk;
      end
      wait_drained();
    end

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/bpc_pkg.sv
sv/bpc_stream_if.sv
sv/bpc_eval.sv
sv/button_press_classifier.sv
verif/button_press_classifier_tb.sv
